// File: rtl/dsp_pkg.sv
package dsp_pkg;

  localparam int unsigned DefaultDepth = 4096;

  // fall divisor 64000 = 2^9 * 125: drop nine bits, then multiply by
  // ceil(2^31 / 125), exact for every 24-bit value
  localparam logic [24:0] FallRecip  = 25'd17179870;
  localparam int unsigned RecipShift = 31;
  // cycles from divider start to a valid quotient
  localparam int unsigned DivSteps   = 2;

  // register indexes
  localparam logic [2:0] RegSpreadX  = 3'd0;
  localparam logic [2:0] RegSpreadY  = 3'd1;
  localparam logic [2:0] RegSpreadZ  = 3'd2;
  localparam logic [2:0] RegSpeedB   = 3'd3;
  localparam logic [2:0] RegSpeedS   = 3'd4;
  localparam logic [2:0] RegPeriod   = 3'd5;
  localparam logic [2:0] RegFloor    = 3'd6;

  typedef struct packed {
    logic signed [15:0] blue;
    logic signed [15:0] green;
    logic signed [15:0] red;
    logic signed [15:0] speed;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } particle_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdWait,
    StRdData,
    StKillRd,
    StKillChk,
    StEmitAcc,
    StEmitMul,
    StShRd,
    StShChk,
    StFallRd,
    StFallMul,
    StFallDiv,
    StFallWait,
    StFallWr,
    StDone
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: rtl/dsp_ram.sv
module dsp_ram #(
  parameter int unsigned Depth = dsp_pkg::DefaultDepth,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  dsp_pkg::particle_t  wdata_i,
  input  logic [Aw-1:0]       raddr_i,
  output dsp_pkg::particle_t  rdata_o
);

  dsp_pkg::particle_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/dsp_div.sv
// divide by the fall constant: drop the low nine bits, then a reciprocal
// multiply by 1/125; quotient valid in the same cycle as done
module dsp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic [23:0] num_q, num_d;
  logic [48:0] prod_q;
  logic [1:0]  cnt_q, cnt_d;

  assign done_o = (cnt_q == 2'd1);
  assign quot_o = 17'(prod_q >> dsp_pkg::RecipShift);

  always_comb begin
    num_d = num_q;
    cnt_d = cnt_q;
    if (start_i) begin
      num_d = dividend_i[32:9];
      cnt_d = 2'(dsp_pkg::DivSteps);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    prod_q <= num_q * dsp_pkg::FallRecip;
  end

endmodule

// File: rtl/depth_sorted_particle_pool.sv
// Depth-sorted particle pool. Live particles sit in slots 0..live_count-1 of one
// on-chip memory, largest depth first. A frame request (tuser = 0) compacts the
// pool by dropping particles below floor_height, may emit one particle
// (4 multiplies on the shared multiplier, then an insertion shift of the slots
// behind the insert place), and then lets every live particle fall (read,
// multiply, and a reciprocal divide by 64000). One request is worked on at a
// time; the next is taken once the sequencer is back in idle, even while the
// previous result still waits on the master side. Config writes are always ready.
module depth_sorted_particle_pool #(
  parameter int unsigned POOL_DEPTH = dsp_pkg::DefaultDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: frame_time, entry_index, rnd_x, rnd_y, rnd_z, rnd_speed, rnd_red,
  //        rnd_green, rnd_blue, zero pad
  input  logic [143:0] s_axis_tdata_i,
  // tuser: mode
  input  logic         s_axis_tuser_i,
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: live_count, emitted, out_x, out_y, out_z, out_speed, out_red,
  //        out_green, out_blue, out_live, zero pad
  output logic [127:0] m_axis_tdata_o
);

  localparam int unsigned Aw = $clog2(POOL_DEPTH);

  // config registers
  logic signed [15:0] spread_x_q, spread_y_q, spread_z_q;
  logic signed [15:0] speed_b_q, speed_s_q, floor_q;
  logic        [15:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_x_q <= -16'sd16384;
      spread_y_q <= -16'sd8192;
      spread_z_q <= 16'sd12288;
      speed_b_q  <= 16'sd2048;
      speed_s_q  <= 16'sd819;
      period_q   <= 16'd256;
      floor_q    <= -16'sd12288;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsp_pkg::RegSpreadX: spread_x_q <= cfg_data_i;
        dsp_pkg::RegSpreadY: spread_y_q <= cfg_data_i;
        dsp_pkg::RegSpreadZ: spread_z_q <= cfg_data_i;
        dsp_pkg::RegSpeedB:  speed_b_q  <= cfg_data_i;
        dsp_pkg::RegSpeedS:  speed_s_q  <= cfg_data_i;
        dsp_pkg::RegPeriod:  period_q   <= cfg_data_i;
        dsp_pkg::RegFloor:   floor_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  dsp_pkg::state_e state_q, state_d;
  logic [Aw-1:0]   k_q, k_d, w_q, w_d, count_q, count_d;
  logic [31:0]     acc_q, acc_d;
  logic [2:0]      step_q, step_d;
  logic            emitted_q, emitted_d;
  logic            rlive_q, rlive_d;
  logic            m_valid_q, m_valid_d;

  // payload
  logic [143:0]       item_q, item_d;
  logic               mode_q, mode_d;
  dsp_pkg::particle_t np_q, np_d, ent_q, ent_d;
  logic [127:0]       out_q, out_d;
  logic signed [33:0] prod_q;

  // item fields
  logic        [15:0] ft;
  logic        [11:0] idx;
  logic signed [15:0] rnd_x, rnd_y, rnd_z, rnd_sp, rnd_r, rnd_g, rnd_b;
  assign ft     = item_q[15:0];
  assign idx    = item_q[27:16];
  assign rnd_x  = item_q[43:28];
  assign rnd_y  = item_q[59:44];
  assign rnd_z  = item_q[75:60];
  assign rnd_sp = item_q[91:76];
  assign rnd_r  = item_q[107:92];
  assign rnd_g  = item_q[123:108];
  assign rnd_b  = item_q[139:124];

  // memory
  logic               ram_we;
  logic [Aw-1:0]      ram_waddr, ram_raddr;
  dsp_pkg::particle_t ram_wdata, ram_rdata;

  dsp_ram #(.Depth(POOL_DEPTH), .Aw(Aw)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared multiplier, registered
  logic signed [16:0] mul_a, mul_b;
  always_comb begin
    mul_a = 17'(rnd_x);
    mul_b = 17'(spread_x_q);
    if (state_q == dsp_pkg::StFallMul) begin
      mul_a = 17'(ram_rdata.speed);
      mul_b = $signed({1'b0, ft});
    end else begin
      case (step_q)
        3'd1: begin mul_a = 17'(rnd_y);  mul_b = 17'(spread_y_q); end
        3'd2: begin mul_a = 17'(rnd_z);  mul_b = 17'(spread_z_q); end
        3'd3: begin mul_a = 17'(rnd_sp); mul_b = 17'(speed_s_q);  end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // round(prod / 2^14)
  logic signed [19:0] scaled;
  assign scaled = 20'((prod_q + 34'sd8192) >>> 14);

  // fall divider: dividend = prod + 32000 + 64000 * 2^16, always positive
  logic        div_start, div_done;
  logic [16:0] div_quot;
  logic signed [33:0] div_num;
  assign div_num   = prod_q + 34'sd32000 + 34'sd4194304000;
  assign div_start = (state_q == dsp_pkg::StFallDiv);

  dsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num[32:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic signed [19:0] fall_d, fall_y;
  assign fall_d = $signed({3'b0, div_quot}) - 20'sd65536;
  assign fall_y = 20'(ent_q.y) - fall_d;

  // accumulator, saturating
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  assign acc_sum = {1'b0, acc_q} + {17'b0, ft};
  assign acc_sat = acc_sum[32] ? 32'hffff_ffff : acc_sum[31:0];

  logic signed [15:0] col_r, col_g, col_b;
  assign col_r = dsp_pkg::sat16(20'((20'(rnd_r) + 20'sd2) >>> 2) + 20'sd2048);
  assign col_g = dsp_pkg::sat16(20'((20'(rnd_g) + 20'sd2) >>> 2) + 20'sd2048);
  assign col_b = dsp_pkg::sat16(20'((20'(rnd_b) + 20'sd2) >>> 2) + 20'sd2048);

  logic accept, out_free, can_emit;
  assign s_axis_tready_o = (state_q == dsp_pkg::StIdle);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign can_emit = (32'(count_q) < 32'(POOL_DEPTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsp_pkg::StIdle:
        if (accept) state_d = s_axis_tuser_i ? dsp_pkg::StRdWait : dsp_pkg::StKillRd;
      dsp_pkg::StRdWait:  state_d = dsp_pkg::StRdData;
      dsp_pkg::StRdData:  state_d = dsp_pkg::StDone;
      dsp_pkg::StKillRd:
        state_d = (k_q == count_q) ? dsp_pkg::StEmitAcc : dsp_pkg::StKillChk;
      dsp_pkg::StKillChk: state_d = dsp_pkg::StKillRd;
      dsp_pkg::StEmitAcc:
        state_d = (acc_sat > 32'(period_q) && can_emit) ? dsp_pkg::StEmitMul
                                                         : dsp_pkg::StFallRd;
      dsp_pkg::StEmitMul:
        if (step_q == 3'd4) state_d = dsp_pkg::StShRd;
      dsp_pkg::StShRd:
        state_d = (k_q == '0) ? dsp_pkg::StFallRd : dsp_pkg::StShChk;
      dsp_pkg::StShChk:
        state_d = (ram_rdata.z < np_q.z) ? dsp_pkg::StShRd : dsp_pkg::StFallRd;
      dsp_pkg::StFallRd:
        state_d = (k_q == count_q) ? dsp_pkg::StDone : dsp_pkg::StFallMul;
      dsp_pkg::StFallMul:  state_d = dsp_pkg::StFallDiv;
      dsp_pkg::StFallDiv:  state_d = dsp_pkg::StFallWait;
      dsp_pkg::StFallWait: if (div_done) state_d = dsp_pkg::StFallWr;
      dsp_pkg::StFallWr:   state_d = dsp_pkg::StFallRd;
      dsp_pkg::StDone:     if (out_free) state_d = dsp_pkg::StIdle;
      default:             state_d = dsp_pkg::StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    k_d       = k_q;
    w_d       = w_q;
    count_d   = count_q;
    acc_d     = acc_q;
    step_d    = step_q;
    emitted_d = emitted_q;
    rlive_d   = rlive_q;
    item_d    = item_q;
    mode_d    = mode_q;
    np_d      = np_q;
    ent_d     = ent_q;
    out_d     = out_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = ram_rdata;
    ram_raddr = k_q;
    case (state_q)
      dsp_pkg::StIdle: begin
        if (accept) begin
          item_d    = s_axis_tdata_i;
          mode_d    = s_axis_tuser_i;
          k_d       = '0;
          w_d       = '0;
          emitted_d = 1'b0;
          rlive_d   = 1'b0;
          ent_d     = '0;
        end
      end
      dsp_pkg::StRdWait: begin
        ram_raddr = Aw'(32'(idx));
      end
      dsp_pkg::StRdData: begin
        rlive_d = (32'(idx) < 32'(count_q));
        ent_d   = ram_rdata;
      end
      dsp_pkg::StKillRd: begin
        if (k_q == count_q) begin
          count_d = w_q;
        end
      end
      dsp_pkg::StKillChk: begin
        if (ram_rdata.y >= floor_q) begin
          ram_we    = 1'b1;
          ram_waddr = w_q;
          w_d       = w_q + Aw'(1);
        end
        k_d = k_q + Aw'(1);
      end
      dsp_pkg::StEmitAcc: begin
        acc_d  = acc_sat;
        step_d = '0;
        k_d    = '0;
        if (acc_sat > 32'(period_q)) begin
          acc_d = '0;
          if (can_emit) begin
            np_d.red   = col_r;
            np_d.green = col_g;
            np_d.blue  = col_b;
          end
        end
      end
      dsp_pkg::StEmitMul: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd1: np_d.x = dsp_pkg::sat16(scaled);
          3'd2: np_d.y = dsp_pkg::sat16(scaled);
          3'd3: np_d.z = dsp_pkg::sat16(scaled);
          3'd4: begin
            np_d.speed = dsp_pkg::sat16(20'(speed_b_q) + scaled);
            k_d        = count_q;
          end
          default: ;
        endcase
      end
      dsp_pkg::StShRd: begin
        ram_raddr = k_q - Aw'(1);
        if (k_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = np_q;
          count_d   = count_q + Aw'(1);
          emitted_d = 1'b1;
        end
      end
      dsp_pkg::StShChk: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        if (ram_rdata.z < np_q.z) begin
          ram_wdata = ram_rdata;
          k_d       = k_q - Aw'(1);
        end else begin
          ram_wdata = np_q;
          count_d   = count_q + Aw'(1);
          emitted_d = 1'b1;
          k_d       = '0;
        end
      end
      dsp_pkg::StFallMul: ent_d = ram_rdata;
      dsp_pkg::StFallWr: begin
        ram_we      = 1'b1;
        ram_waddr   = k_q;
        ram_wdata   = ent_q;
        ram_wdata.y = dsp_pkg::sat16(fall_y);
        k_d         = k_q + Aw'(1);
      end
      dsp_pkg::StDone: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (mode_q && rlive_q) begin
            out_d = {2'b0, 1'b1, ent_q, 1'b0, 12'(count_q)};
          end else begin
            out_d = {2'b0, 1'b0, 112'b0, emitted_q, 12'(count_q)};
          end
        end
      end
      default: ;
    endcase
    // shift start and fall start both begin from the proper index
    if (state_q == dsp_pkg::StEmitAcc && !(acc_sat > 32'(period_q) && can_emit)) begin
      k_d = '0;
    end
    if (state_q == dsp_pkg::StShRd && k_q == '0) begin
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dsp_pkg::StIdle;
      k_q       <= '0;
      w_q       <= '0;
      count_q   <= '0;
      acc_q     <= '0;
      step_q    <= '0;
      emitted_q <= 1'b0;
      rlive_q   <= 1'b0;
      m_valid_q <= 1'b0;
      mode_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      w_q       <= w_d;
      count_q   <= count_d;
      acc_q     <= acc_d;
      step_q    <= step_d;
      emitted_q <= emitted_d;
      rlive_q   <= rlive_d;
      m_valid_q <= m_valid_d;
      mode_q    <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    np_q   <= np_d;
    ent_q  <= ent_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // pool never grows past one below its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(POOL_DEPTH - 1))
    else $error("particle count out of range");

  // memory is left alone while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsp_pkg::StIdle) |-> !ram_we)
    else $error("pool written while idle");

  // compaction write pointer never overtakes the read pointer
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsp_pkg::StKillChk) |-> (w_q <= k_q))
    else $error("compaction pointer overtook scan");

endmodule
